[design/sasc_pkg.sv]
// ----------------------------------------------------------------------------
// sasc_pkg
// shared types and constants of the spin axis stability check
// ----------------------------------------------------------------------------
package sasc_pkg;

	typedef enum logic [1:0] {
		VERDICT_STABLE     = 2'd0,
		VERDICT_UNSTABLE   = 2'd1,
		VERDICT_DEGENERATE = 2'd2
	} verdict_t;

	localparam logic [2:0] CFG_INERTIA0  = 3'd0;
	localparam logic [2:0] CFG_INERTIA1  = 3'd1;
	localparam logic [2:0] CFG_INERTIA2  = 3'd2;
	localparam logic [2:0] CFG_TOLERANCE = 3'd3;
	localparam logic [2:0] CFG_THRESHOLD = 3'd4;

	typedef struct packed {
		logic [31:0] inertia0;
		logic [31:0] inertia1;
		logic [31:0] inertia2;
		logic [31:0] tolerance;
		logic [31:0] threshold;
	} cfg_t;

	// kind UNSTABLE here means "candidate, decided by the threshold"
	typedef struct packed {
		verdict_t    kind;
		logic [63:0] w2;
		logic [63:0] p;
		logic [63:0] den;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[design/spin_axis_stability_check.sv]
// path: the two front registers, then the queue, then the back, whose divider and
// root are fully pipelined (64 divide steps, 32 root steps)
// throughput: one word per cycle unless out_ready or a full queue holds the flow
// reset: arst_n clears all valid bits and the queue, moments to 1.0, tolerance
// and threshold to 0
// ----------------------------------------------------------------------------
// spin_axis_stability_check
// intermediate axis stability test with configured principal moments
// ----------------------------------------------------------------------------
module spin_axis_stability_check import sasc_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         axis,
	input  logic signed [31:0] spin_rate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         verdict,
	output logic [31:0]        growth
);

	cfg_t      cfg_q;
	logic      work_valid, work_pop, push;
	work_t     front_work, queue_work;
	q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inertia0  <= 32'd65536;
			cfg_q.inertia1  <= 32'd65536;
			cfg_q.inertia2  <= 32'd65536;
			cfg_q.tolerance <= 32'd0;
			cfg_q.threshold <= 32'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_INERTIA0:  cfg_q.inertia0  <= cfg_data;
				CFG_INERTIA1:  cfg_q.inertia1  <= cfg_data;
				CFG_INERTIA2:  cfg_q.inertia2  <= cfg_data;
				CFG_TOLERANCE: cfg_q.tolerance <= cfg_data;
				CFG_THRESHOLD: cfg_q.threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	sasc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.axis       (axis),
		.spin_rate  (spin_rate),
		.work_valid (work_valid),
		.work       (front_work),
		.work_ready (!q_status.full)
	);

	assign push = work_valid && !q_status.full;

	sasc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_work),
		.pop       (work_pop),
		.pop_data  (queue_work),
		.status    (q_status)
	);

	sasc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.threshold  (cfg_q.threshold),
		.work_valid (!q_status.empty),
		.work       (queue_work),
		.work_pop   (work_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.verdict    (verdict),
		.growth     (growth)
	);

	// only an unstable result carries a growth rate
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict != VERDICT_UNSTABLE |-> growth == 32'd0)
		else $error("growth rate nonzero on a result that is not unstable");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict != 2'd3)
		else $error("undefined verdict code");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue full and empty at once");

	// the front stalls only on a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> work_valid && q_status.full)
		else $error("front stalled without a full queue");

endmodule

[design/sasc_front.sv]
// ----------------------------------------------------------------------------
// sasc_front
// picks the axes, classifies the word and forms the three narrow products
// ----------------------------------------------------------------------------
module sasc_front import sasc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         axis,
	input  logic signed [31:0] spin_rate,
	output logic               work_valid,
	output work_t              work,
	input  logic               work_ready
);

	logic [31:0] ik, ii, ij, a1, a2, mag;
	logic [32:0] d1, d2;
	logic        degen;
	verdict_t    kind;
	logic        en;

	logic        valid_s1, valid_s2;
	verdict_t    kind_s1;
	logic [31:0] mag_s1, a1_s1, a2_s1, ii_s1, ij_s1;
	work_t       work_s2;

	always_comb begin
		ik = (axis == 2'd0) ? cfg.inertia0 : ((axis == 2'd1) ? cfg.inertia1 : cfg.inertia2);
		ii = (axis == 2'd0) ? cfg.inertia1 : cfg.inertia0;
		ij = (axis == 2'd2) ? cfg.inertia1 : cfg.inertia2;
		d1 = {1'b0, ik} - {1'b0, ij};
		d2 = {1'b0, ii} - {1'b0, ik};
		a1 = d1[32] ? (~d1[31:0] + 32'd1) : d1[31:0];
		a2 = d2[32] ? (~d2[31:0] + 32'd1) : d2[31:0];
		degen = (axis == 2'd3) || (a1 <= cfg.tolerance) || (a2 <= cfg.tolerance)
			|| (ii == 32'd0) || (ij == 32'd0);
		if (degen) begin
			kind = VERDICT_DEGENERATE;
		end else if (d1[32] != d2[32]) begin
			kind = VERDICT_STABLE;
		end else begin
			kind = VERDICT_UNSTABLE;
		end
		// most negative rate negates to itself, which is its magnitude
		mag = spin_rate[31] ? (~spin_rate + 32'd1) : spin_rate;
	end

	assign en = !valid_s2 || work_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1      <= kind;
			mag_s1       <= mag;
			a1_s1        <= a1;
			a2_s1        <= a2;
			ii_s1        <= ii;
			ij_s1        <= ij;
			work_s2.kind <= kind_s1;
			work_s2.w2   <= {32'd0, mag_s1} * {32'd0, mag_s1};
			work_s2.p    <= {32'd0, a1_s1} * {32'd0, a2_s1};
			work_s2.den  <= {32'd0, ii_s1} * {32'd0, ij_s1};
		end
	end

	assign work_valid = valid_s2;
	assign work = work_s2;

endmodule

[design/sasc_queue.sv]
// ----------------------------------------------------------------------------
// sasc_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module sasc_queue import sasc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  work_t     push_data,
	input  logic      pop,
	output work_t     pop_data,
	output q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	work_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[design/sasc_back.sv]
// ----------------------------------------------------------------------------
// sasc_back
// wide product, pipelined 128/64 divide, threshold and pipelined square root
// ----------------------------------------------------------------------------
module sasc_back import sasc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] threshold,
	input  logic        work_valid,
	input  work_t       work,
	output logic        work_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict,
	output logic [31:0] growth
);

	localparam int DIV_STEPS = 64;
	localparam int SQ_STEPS  = 32;

	logic en;

	// partial products
	logic        valid_m1;
	verdict_t    kind_m1;
	logic [63:0] den_m1, pp00_m1, pp01_m1, pp10_m1, pp11_m1;
	// summed product
	logic         valid_m2;
	verdict_t     kind_m2;
	logic [63:0]  den_m2;
	logic [127:0] prod_m2;
	// divider stages
	logic        dv_valid_s [DIV_STEPS+1];
	verdict_t    dv_kind_s  [DIV_STEPS+1];
	logic        dv_sat_s   [DIV_STEPS+1];
	logic [63:0] dv_den_s   [DIV_STEPS+1];
	logic [63:0] dv_rem_s   [DIV_STEPS+1];
	logic [63:0] dv_x_s     [DIV_STEPS+1];
	// threshold stage
	logic        th_valid_s;
	verdict_t    th_kind_s;
	logic [63:0] th_lsq_s;
	logic [63:0] lsq;
	// square root stages
	logic        sq_valid_s [SQ_STEPS+1];
	verdict_t    sq_kind_s  [SQ_STEPS+1];
	logic [63:0] sq_rem_s   [SQ_STEPS+1];
	logic [31:0] sq_root_s  [SQ_STEPS+1];
	// output register
	logic        out_valid_q;
	verdict_t    verdict_q;
	logic [31:0] growth_q;

	assign en = !out_valid_q || out_ready;
	assign work_pop = en && work_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m1    <= 1'b0;
			valid_m2    <= 1'b0;
			th_valid_s  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int n = 0; n <= DIV_STEPS; n++) begin
				dv_valid_s[n] <= 1'b0;
			end
			for (int n = 0; n <= SQ_STEPS; n++) begin
				sq_valid_s[n] <= 1'b0;
			end
		end else if (en) begin
			valid_m1      <= work_valid;
			valid_m2      <= valid_m1;
			dv_valid_s[0] <= valid_m2;
			for (int n = 0; n < DIV_STEPS; n++) begin
				dv_valid_s[n+1] <= dv_valid_s[n];
			end
			th_valid_s    <= dv_valid_s[DIV_STEPS];
			sq_valid_s[0] <= th_valid_s;
			for (int n = 0; n < SQ_STEPS; n++) begin
				sq_valid_s[n+1] <= sq_valid_s[n];
			end
			out_valid_q <= sq_valid_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_m1 <= work.kind;
			den_m1  <= work.den;
			pp00_m1 <= {32'd0, work.w2[31:0]}  * {32'd0, work.p[31:0]};
			pp01_m1 <= {32'd0, work.w2[31:0]}  * {32'd0, work.p[63:32]};
			pp10_m1 <= {32'd0, work.w2[63:32]} * {32'd0, work.p[31:0]};
			pp11_m1 <= {32'd0, work.w2[63:32]} * {32'd0, work.p[63:32]};
			kind_m2 <= kind_m1;
			den_m2  <= den_m1;
			prod_m2 <= {64'd0, pp00_m1} + ({64'd0, pp01_m1} << 32)
				+ ({64'd0, pp10_m1} << 32) + {pp11_m1, 64'd0};
			dv_kind_s[0] <= kind_m2;
			dv_den_s[0]  <= den_m2;
			dv_sat_s[0]  <= (prod_m2[127:64] >= den_m2);
			dv_rem_s[0]  <= prod_m2[127:64];
			dv_x_s[0]    <= prod_m2[63:0];
		end
	end

	// one quotient bit per stage, quotient bits fill x from the bottom
	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		logic [64:0] trial, diff;
		logic        ge;
		always_comb begin
			trial = {dv_rem_s[g], dv_x_s[g][63]};
			diff  = trial - {1'b0, dv_den_s[g]};
			ge    = (trial >= {1'b0, dv_den_s[g]});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_kind_s[g+1] <= dv_kind_s[g];
				dv_den_s[g+1]  <= dv_den_s[g];
				dv_sat_s[g+1]  <= dv_sat_s[g];
				dv_rem_s[g+1]  <= ge ? diff[63:0] : trial[63:0];
				dv_x_s[g+1]    <= {dv_x_s[g][62:0], ge};
			end
		end
	end

	assign lsq = dv_sat_s[DIV_STEPS] ? 64'hFFFF_FFFF_FFFF_FFFF : dv_x_s[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			th_lsq_s <= lsq;
			if (dv_kind_s[DIV_STEPS] == VERDICT_UNSTABLE && lsq <= {32'd0, threshold}) begin
				th_kind_s <= VERDICT_STABLE;
			end else begin
				th_kind_s <= dv_kind_s[DIV_STEPS];
			end
			sq_kind_s[0] <= th_kind_s;
			sq_rem_s[0]  <= th_lsq_s;
			sq_root_s[0] <= '0;
			verdict_q    <= sq_kind_s[SQ_STEPS];
			growth_q     <= (sq_kind_s[SQ_STEPS] == VERDICT_UNSTABLE) ? sq_root_s[SQ_STEPS] : '0;
		end
	end

	// root bit 31-g per stage, remainder holds x minus root squared
	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		localparam int B = SQ_STEPS - 1 - g;
		logic [65:0] inc;
		logic        ge;
		always_comb begin
			inc = ({34'd0, sq_root_s[g]} << (B + 1)) + (66'd1 << (2 * B));
			ge  = ({2'b0, sq_rem_s[g]} >= inc);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_kind_s[g+1] <= sq_kind_s[g];
				sq_rem_s[g+1]  <= ge ? 64'({2'b0, sq_rem_s[g]} - inc) : sq_rem_s[g];
				sq_root_s[g+1] <= ge ? (sq_root_s[g] | (32'd1 << B)) : sq_root_s[g];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;
	assign growth = growth_q;

endmodule
